>>> rtl/bptg_pkg.sv
// ----------------------------------------------------------------------------
// bptg_pkg
// Shared widths, register indexes and types of the burst pulse train generator.
// ----------------------------------------------------------------------------
package bptg_pkg;

  localparam int TIME_WIDTH  = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_BLK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_GAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 3'd5;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  start_delay_us;
    logic [TIME_WIDTH-1:0]  pulse_high_us;
    logic [TIME_WIDTH-1:0]  pulse_low_us;
    logic [COUNT_WIDTH-1:0] pulses_per_block;
    logic [TIME_WIDTH-1:0]  block_gap_us;
    logic [COUNT_WIDTH-1:0] block_count;
  } cfg_t;

  typedef struct packed {
    logic                   ttl_level;
    logic [COUNT_WIDTH-1:0] pulse_number;
    logic [COUNT_WIDTH-1:0] block_number;
    logic                   pulse_finished;
    logic [TIME_WIDTH-1:0]  rise_time_us;
    logic                   run_done;
  } result_t;

endpackage

>>> rtl/bptg_cfg_regs.sv
// ----------------------------------------------------------------------------
// bptg_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module bptg_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bptg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bptg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bptg_pkg::cfg_t                    cfg
);
  import bptg_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delay_us   <= '0;
      cfg_r.pulse_high_us    <= TIME_WIDTH'(1);
      cfg_r.pulse_low_us     <= TIME_WIDTH'(1);
      cfg_r.pulses_per_block <= COUNT_WIDTH'(1);
      cfg_r.block_gap_us     <= '0;
      cfg_r.block_count      <= COUNT_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_DELAY: cfg_r.start_delay_us   <= cfg_data[TIME_WIDTH-1:0];
        REG_PULSE_HIGH:  cfg_r.pulse_high_us    <= cfg_data[TIME_WIDTH-1:0];
        REG_PULSE_LOW:   cfg_r.pulse_low_us     <= cfg_data[TIME_WIDTH-1:0];
        REG_PULSES_BLK:  cfg_r.pulses_per_block <= cfg_data[COUNT_WIDTH-1:0];
        REG_BLOCK_GAP:   cfg_r.block_gap_us     <= cfg_data[TIME_WIDTH-1:0];
        REG_BLOCK_COUNT: cfg_r.block_count      <= cfg_data[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/bptg_in_stage.sv
// ----------------------------------------------------------------------------
// bptg_in_stage
// Input register for the tick channel; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module bptg_in_stage (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_restart,
  input  logic advance,
  output logic tick_valid,
  output logic tick_restart
);
  import bptg_pkg::*;

  logic vld_r;
  logic restart_r;

  assign in_ready     = !vld_r || advance;
  assign tick_valid   = vld_r;
  assign tick_restart = restart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      restart_r <= in_restart;
    end
  end

endmodule

>>> rtl/bptg_core.sv
// ----------------------------------------------------------------------------
// bptg_core
// Sequencer state and the per-tick edge logic: fall first, then rise.
// ----------------------------------------------------------------------------
module bptg_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic               restart,
  input  bptg_pkg::cfg_t     cfg,
  output bptg_pkg::result_t  res
);
  import bptg_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]             phase_r,   phase_nxt;
  logic [TIME_WIDTH-1:0]  elapsed_r, elapsed_nxt;
  logic [TIME_WIDTH-1:0]  target_r,  target_nxt;
  logic [COUNT_WIDTH-1:0] pulse_r,   pulse_nxt;
  logic [COUNT_WIDTH-1:0] block_r,   block_nxt;
  logic [TIME_WIDTH-1:0]  rise_r,    rise_nxt;

  logic [1:0]             ph0, ph1;
  logic [TIME_WIDTH-1:0]  tgt0;
  logic [COUNT_WIDTH-1:0] pc0, bc0, np, np2, nb;
  logic [TIME_WIDTH-1:0]  high_t, incr, t_high, t_low, t_low_gap;
  logic                   hit, fall, blk_wrap, run_end, rise;

  always_comb begin
    // restart re-arms with elapsed time zero on this tick
    if (restart) begin
      elapsed_nxt = '0;
      tgt0        = cfg.start_delay_us;
      pc0         = '0;
      bc0         = '0;
      ph0         = (cfg.pulses_per_block == '0 || cfg.block_count == '0) ? PH_DONE : PH_WAIT;
    end else begin
      elapsed_nxt = elapsed_r + TIME_WIDTH'(1);
      tgt0        = target_r;
      pc0         = pulse_r;
      bc0         = block_r;
      ph0         = phase_r;
    end

    hit       = (elapsed_nxt == tgt0);
    high_t    = (cfg.pulse_high_us == '0) ? TIME_WIDTH'(1) : cfg.pulse_high_us;
    t_high    = tgt0 + high_t;
    t_low     = tgt0 + cfg.pulse_low_us;
    t_low_gap = tgt0 + cfg.pulse_low_us + cfg.block_gap_us;

    fall     = (ph0 == PH_HIGH) && hit;
    np       = pc0 + COUNT_WIDTH'(1);
    blk_wrap = (np >= cfg.pulses_per_block);
    np2      = blk_wrap ? '0 : np;
    nb       = blk_wrap ? bc0 + COUNT_WIDTH'(1) : bc0;
    incr     = blk_wrap ? cfg.pulse_low_us + cfg.block_gap_us : cfg.pulse_low_us;
    run_end  = (np2 == '0) && (nb >= cfg.block_count);

    ph1       = ph0;
    pulse_nxt = pc0;
    block_nxt = bc0;
    if (fall) begin
      if (run_end) begin
        ph1 = PH_DONE;
      end else begin
        ph1       = PH_WAIT;
        pulse_nxt = np2;
        block_nxt = nb;
      end
    end

    // after a fall the target is now only when low time plus any block gap is zero
    rise = (ph1 == PH_WAIT) && (fall ? (incr == '0) : hit);

    phase_nxt = rise ? PH_HIGH : ph1;
    rise_nxt  = rise ? elapsed_nxt : rise_r;
    priority if (rise) begin
      target_nxt = t_high;
    end else if (fall) begin
      target_nxt = blk_wrap ? t_low_gap : t_low;
    end else begin
      target_nxt = tgt0;
    end

    res.ttl_level      = (phase_nxt == PH_HIGH);
    res.pulse_number   = fall ? pc0 : pulse_nxt;
    res.block_number   = fall ? bc0 : block_nxt;
    res.pulse_finished = fall;
    res.rise_time_us   = fall ? rise_r : '0;
    res.run_done       = (phase_nxt == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      target_r  <= '0;
      pulse_r   <= '0;
      block_r   <= '0;
      rise_r    <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      target_r  <= target_nxt;
      pulse_r   <= pulse_nxt;
      block_r   <= block_nxt;
      rise_r    <= rise_nxt;
    end
  end

endmodule

>>> rtl/bptg_out_stage.sv
// ----------------------------------------------------------------------------
// bptg_out_stage
// Result register; takes a new result whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module bptg_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  bptg_pkg::result_t  res,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output bptg_pkg::result_t  out_res
);
  import bptg_pkg::*;

  logic    vld_r;
  result_t res_r;

  assign can_load  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (can_load) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

>>> rtl/burst_pulse_train_generator.sv
// ----------------------------------------------------------------------------
// burst_pulse_train_generator
// TTL burst stimulus sequencer driven by one tick transfer per microsecond.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transfer per timebase tick; in_restart re-arms the run with
//            elapsed time zero at that tick.
//   out_*  : one result transfer per tick: level, pulse and block index,
//            pulse_finished with the rise time of the pulse that fell, run_done.
//   cfg_*  : register writes (index 0..5), always ready; write only while the
//            block is idle. Registers are read live at each edge.
// Each tick is registered in the input register and its result in the result
// register; throughput is one tick per cycle while out_ready stays high, as the
// state update (elapsed count compare and edge-target add) is combinational.
// Reset: phase idle, level low, counters and times zero, registers at their
// defaults; the block leaves idle only on a restart tick.
// Stall: while out_ready is low a valid result register holds and the input
// register fills once, after which in_ready drops until the result moves.
// ----------------------------------------------------------------------------
module burst_pulse_train_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_ttl_level,
  output logic [bptg_pkg::COUNT_WIDTH-1:0] out_pulse_number,
  output logic [bptg_pkg::COUNT_WIDTH-1:0] out_block_number,
  output logic                            out_pulse_finished,
  output logic [bptg_pkg::TIME_WIDTH-1:0]  out_rise_time_us,
  output logic                            out_run_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bptg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bptg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bptg_pkg::*;

  cfg_t    cfg;
  result_t res, out_res;
  logic    tick_valid, tick_restart, can_load, advance;

  assign advance = tick_valid && can_load;

  bptg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bptg_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_restart   (in_restart),
    .advance      (advance),
    .tick_valid   (tick_valid),
    .tick_restart (tick_restart)
  );

  bptg_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .restart (tick_restart),
    .cfg     (cfg),
    .res     (res)
  );

  bptg_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_ttl_level      = out_res.ttl_level;
  assign out_pulse_number   = out_res.pulse_number;
  assign out_block_number   = out_res.block_number;
  assign out_pulse_finished = out_res.pulse_finished;
  assign out_rise_time_us   = out_res.rise_time_us;
  assign out_run_done       = out_res.run_done;

endmodule

>>> rtl/bptg_checker.sv
// ----------------------------------------------------------------------------
// bptg_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bptg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_ttl_level,
  input logic [bptg_pkg::COUNT_WIDTH-1:0] out_pulse_number,
  input logic [bptg_pkg::COUNT_WIDTH-1:0] out_block_number,
  input logic                             out_pulse_finished,
  input logic [bptg_pkg::TIME_WIDTH-1:0]  out_rise_time_us,
  input logic                             out_run_done
);
  import bptg_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_number) &&
      $stable(out_block_number) && $stable(out_rise_time_us) &&
      $stable(out_ttl_level) && $stable(out_run_done) && $stable(out_pulse_finished))
    else $error("result changed while stalled");

  a_rise_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pulse_finished |-> out_rise_time_us == '0)
    else $error("rise time reported without a finished pulse");

  a_done_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_done |-> !out_ttl_level)
    else $error("level high after run done");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind burst_pulse_train_generator bptg_checker u_bptg_checker (.*);

>>> test/burst_pulse_train_generator_tb.sv
// ----------------------------------------------------------------------------
// burst_pulse_train_generator_tb
// Self-checking bench for the burst pulse train generator: a queue-fed tick
// driver, a random-stall receiver and a cycle-true predictor of level,
// indices, finished-pulse rise times and run completion, checked per result.
// ----------------------------------------------------------------------------
module burst_pulse_train_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bptg_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;
  localparam int TICK_TARGET  = 700;
  localparam int SETTLE       = 4;

  // indexes beyond the register file; writes there must have no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum logic [1:0] {ST_IDLE, ST_LOW, ST_HIGH, ST_DONE} train_state_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic                   in_restart = 1'b0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic                   out_ttl_level;
  logic [COUNT_WIDTH-1:0] out_pulse_number;
  logic [COUNT_WIDTH-1:0] out_block_number;
  logic                   out_pulse_finished;
  logic [TIME_WIDTH-1:0]  out_rise_time_us;
  logic                   out_run_done;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  burst_pulse_train_generator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ttl_level      (out_ttl_level),
    .out_pulse_number   (out_pulse_number),
    .out_block_number   (out_block_number),
    .out_pulse_finished (out_pulse_finished),
    .out_rise_time_us   (out_rise_time_us),
    .out_run_done       (out_run_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // pending ticks and the expected result of every accepted tick
  bit      tick_q[$];
  result_t level_q[$];

  // predictor copy of the registers and the sequencer state
  cfg_t                   shadow_regs;
  train_state_t           train_state = ST_IDLE;
  logic [TIME_WIDTH-1:0]  elapsed_us  = '0;
  logic [TIME_WIDTH-1:0]  edge_target = '0;
  logic [TIME_WIDTH-1:0]  rise_stamp  = '0;
  logic [COUNT_WIDTH-1:0] pulse_idx   = '0;
  logic [COUNT_WIDTH-1:0] block_idx   = '0;

  logic [CFG_DATA_W-1:0]  reg_plan [6];

  bit in_taken;
  int ticks_queued;
  int ticks_taken;
  int error_count;
  int stall_cycles;
  int pulses_seen;
  int settings_used;

  task automatic advance_train(input bit restart, output result_t r);
    logic [COUNT_WIDTH-1:0] np;
    logic [COUNT_WIDTH-1:0] nb;
    logic [COUNT_WIDTH-1:0] pn;
    logic [COUNT_WIDTH-1:0] bn;
    logic [TIME_WIDTH-1:0]  rise;
    bit                     fin;
    fin  = 1'b0;
    rise = '0;
    if (restart) begin
      elapsed_us  = '0;
      pulse_idx   = '0;
      block_idx   = '0;
      edge_target = shadow_regs.start_delay_us;
      train_state = (shadow_regs.pulses_per_block == 0 || shadow_regs.block_count == 0) ?
                    ST_DONE : ST_LOW;
    end else begin
      elapsed_us = elapsed_us + 1'b1;
    end
    pn = pulse_idx;
    bn = block_idx;
    // fall first, so a zero low time can rise again on the same tick
    if (train_state == ST_HIGH && elapsed_us == edge_target) begin
      np          = pulse_idx + 1'b1;
      nb          = block_idx;
      fin         = 1'b1;
      rise        = rise_stamp;
      edge_target = edge_target + shadow_regs.pulse_low_us;
      if (np >= shadow_regs.pulses_per_block) begin
        np          = '0;
        nb          = nb + 1'b1;
        edge_target = edge_target + shadow_regs.block_gap_us;
      end
      if (np == 0 && nb >= shadow_regs.block_count) begin
        train_state = ST_DONE;
      end else begin
        train_state = ST_LOW;
        pulse_idx   = np;
        block_idx   = nb;
      end
    end
    if (train_state == ST_LOW && elapsed_us == edge_target) begin
      rise_stamp  = elapsed_us;
      edge_target = edge_target + ((shadow_regs.pulse_high_us == 0) ?
                                   TIME_WIDTH'(1) : shadow_regs.pulse_high_us);
      train_state = ST_HIGH;
    end
    if (!fin) begin
      pn = pulse_idx;
      bn = block_idx;
    end
    r.ttl_level      = (train_state == ST_HIGH);
    r.pulse_number   = pn;
    r.block_number   = bn;
    r.pulse_finished = fin;
    r.rise_time_us   = rise;
    r.run_done       = (train_state == ST_DONE);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  function automatic int idle_pct(input bit sender);
    if (ticks_taken < TICK_TARGET / 3) return sender ? 22 : 59;
    if (ticks_taken < 2 * TICK_TARGET / 3) return sender ? 59 : 22;
    return 0;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] small_or_wide(input int hi);
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(hi);
  endfunction

  // tick driver: hold the payload until the transfer, then advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
        in_valid   <= 1'b1;
        in_restart <= tick_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    in_taken = in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          $error("result transfer with nothing expected");
          error_count++;
        end else begin
          want = level_q.pop_front();
          check_field("ttl_level", 32'(want.ttl_level), 32'(out_ttl_level));
          check_field("pulse_number", 32'(want.pulse_number), 32'(out_pulse_number));
          check_field("block_number", 32'(want.block_number), 32'(out_block_number));
          check_field("pulse_finished", 32'(want.pulse_finished), 32'(out_pulse_finished));
          check_field("rise_time_us", want.rise_time_us, out_rise_time_us);
          check_field("run_done", 32'(want.run_done), 32'(out_run_done));
          if (want.pulse_finished) pulses_seen++;
        end
      end
      if (in_taken) begin
        advance_train(in_restart, fresh);
        level_q.push_back(fresh);
        ticks_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_DELAY: shadow_regs.start_delay_us   = cfg_data;
          REG_PULSE_HIGH:  shadow_regs.pulse_high_us    = cfg_data;
          REG_PULSE_LOW:   shadow_regs.pulse_low_us     = cfg_data;
          REG_PULSES_BLK:  shadow_regs.pulses_per_block = cfg_data[COUNT_WIDTH-1:0];
          REG_BLOCK_GAP:   shadow_regs.block_gap_us     = cfg_data;
          REG_BLOCK_COUNT: shadow_regs.block_count      = cfg_data[COUNT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with no transfer", STALL_LIMIT);
    $display("FAIL burst_pulse_train_generator");
    $finish;
  end

  // write every register from reg_plan, optionally poking the spare indexes
  task automatic set_regs(input bit poke_spare);
    int last;
    last = poke_spare ? int'(REG_SPARE_B) : int'(REG_BLOCK_COUNT);
    for (int i = REG_START_DELAY; i <= last; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= (i > REG_BLOCK_COUNT) ? CFG_DATA_W'($urandom) : reg_plan[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_pattern(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      tick_q.push_back(bits[i]);
      ticks_queued++;
    end
  endtask

  // wait for every tick to land, then let the pipeline settle
  task automatic drain();
    while (tick_q.size() != 0 || in_valid || level_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic plan(input logic [31:0] sd, input logic [31:0] hi, input logic [31:0] lo,
                      input logic [31:0] ppb, input logic [31:0] gap, input logic [31:0] cnt);
    reg_plan[REG_START_DELAY] = sd;
    reg_plan[REG_PULSE_HIGH]  = hi;
    reg_plan[REG_PULSE_LOW]   = lo;
    reg_plan[REG_PULSES_BLK]  = ppb;
    reg_plan[REG_BLOCK_GAP]   = gap;
    reg_plan[REG_BLOCK_COUNT] = cnt;
  endtask

  initial begin
    int len;
    shadow_regs.start_delay_us   = '0;
    shadow_regs.pulse_high_us    = TIME_WIDTH'(1);
    shadow_regs.pulse_low_us     = TIME_WIDTH'(1);
    shadow_regs.pulses_per_block = COUNT_WIDTH'(1);
    shadow_regs.block_gap_us     = '0;
    shadow_regs.block_count      = COUNT_WIDTH'(1);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // defaults: idle ticks, then a single one-pulse run
    queue_pattern(32'b001000, 6);
    drain();

    // zero high time, zero low time, gaps between blocks
    plan(2, 0, 0, 3, 1, 2);
    set_regs(1'b1);
    queue_pattern(32'b100000000, 9);
    drain();

    // empty runs: no pulses per block, then no blocks with the longest delay
    plan(1, 1, 1, 0, 0, 3);
    set_regs(1'b0);
    queue_pattern(32'b10, 2);
    drain();
    plan(32'hFFFF_FFFF, 1, 1, 2, 0, 0);
    set_regs(1'b0);
    queue_pattern(32'b10, 2);
    drain();

    // widest values: edge targets wrap, restart mid-pulse
    plan(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF);
    set_regs(1'b1);
    queue_pattern(32'b10001, 5);
    drain();

    while (ticks_queued < TICK_TARGET) begin
      plan(small_or_wide(5), small_or_wide(4), small_or_wide(3),
           small_or_wide(4), small_or_wide(4), small_or_wide(3));
      // keep empty runs rare
      if (reg_plan[REG_PULSES_BLK] == 0 && $urandom_range(3) != 0)
        reg_plan[REG_PULSES_BLK] = 1;
      if (reg_plan[REG_BLOCK_COUNT] == 0 && $urandom_range(3) != 0)
        reg_plan[REG_BLOCK_COUNT] = 1;
      set_regs($urandom_range(7) == 0);
      len = $urandom_range(20, 60);
      // a third of the settings land on a run already under way
      for (int i = 0; i < len; i++) begin
        tick_q.push_back((i == 0) ? ($urandom_range(2) != 0) : ($urandom_range(39) == 0));
        ticks_queued++;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d ticks under %0d register settings, %0d pulses finished,",
             ticks_taken, settings_used, pulses_seen);
    $display("with sender and receiver stalls swapped mid-run and a stall-free tail.");
    if (error_count == 0) begin
      $display("PASS burst_pulse_train_generator");
    end else begin
      $display("FAIL burst_pulse_train_generator");
    end
    $finish;
  end

endmodule

>>> burst_pulse_train_generator.f
rtl/bptg_pkg.sv
rtl/bptg_cfg_regs.sv
rtl/bptg_in_stage.sv
rtl/bptg_core.sv
rtl/bptg_out_stage.sv
rtl/burst_pulse_train_generator.sv
rtl/bptg_checker.sv
test/burst_pulse_train_generator_tb.sv
